@@ hw/rtl/soft_power_button_controller_assert.svh @@
`ifndef SOFT_POWER_BUTTON_CONTROLLER_ASSERT_SVH
`define SOFT_POWER_BUTTON_CONTROLLER_ASSERT_SVH

// check that a condition implies a property on the same edge
`define SPBC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that two conditions are never true together
`define SPBC_ASSERT_EXCLUSIVE(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !((a) && (b))) \
		else $error(msg);

`endif

@@ hw/rtl/spbc_pkg.sv @@
package spbc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_WIDTH = 3;
	localparam int REG_IDX_LSB = 2;
	localparam int EXT_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	localparam logic [CFG_WIDTH-1:0] GRACE_RESET = CFG_WIDTH'(100);
	localparam logic [CFG_WIDTH-1:0] FORCE_RESET = CFG_WIDTH'(400);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic {
		REG_GRACE = 1'b0,
		REG_FORCE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] grace_ticks;
		logic [CFG_WIDTH-1:0] force_off_ticks;
	} cfg_t;

	typedef struct packed {
		logic mode;
		logic pwr_ok;
		logic off_request;
		logic switch_pressed;
	} in_item_t;

	typedef struct packed {
		logic psu_on;
		logic psu_off;
		logic assert_shutdown;
		logic deassert_shutdown;
		logic shutdown_level;
	} out_item_t;

	function automatic count_t clamp_count(input logic [CFG_WIDTH-1:0] v);
		logic [EXT_WIDTH-1:0] ext;
		ext = EXT_WIDTH'(v);
		if (ext > EXT_WIDTH'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return COUNT_WIDTH'(ext);
	endfunction

endpackage

@@ hw/rtl/spbc_cfg.sv @@
module spbc_cfg import spbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx = reg_idx_t'(paddr[REG_IDX_LSB]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grace_ticks <= GRACE_RESET;
			cfg_q.force_off_ticks <= FORCE_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_GRACE: cfg_q.grace_ticks <= pwdata[CFG_WIDTH-1:0];
				REG_FORCE: cfg_q.force_off_ticks <= pwdata[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GRACE: prdata = DATA_WIDTH'(cfg_q.grace_ticks);
			REG_FORCE: prdata = DATA_WIDTH'(cfg_q.force_off_ticks);
			default: prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/spbc_core.sv @@
module spbc_core import spbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	logic      adv_s1;

	logic   prev_pressed_q, on_pending_q, button_armed_q, forced_done_q;
	logic   shutdown_asserted_q, seen_released_q;
	count_t hold_count_q, grace_count_q;

	logic   prev_pressed_d, on_pending_d, button_armed_d, forced_done_d;
	logic   shutdown_asserted_d, seen_released_d;
	count_t hold_count_d, grace_count_d;
	out_item_t res_d;

	assign adv_s1 = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv_s1;
	assign result_valid = valid_s2;
	assign result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			result_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= 1'b0;
			on_pending_q <= 1'b0;
			button_armed_q <= 1'b0;
			forced_done_q <= 1'b0;
			shutdown_asserted_q <= 1'b0;
			seen_released_q <= 1'b0;
			hold_count_q <= '0;
			grace_count_q <= clamp_count(GRACE_RESET);
		end else if (adv_s1) begin
			prev_pressed_q <= prev_pressed_d;
			on_pending_q <= on_pending_d;
			button_armed_q <= button_armed_d;
			forced_done_q <= forced_done_d;
			shutdown_asserted_q <= shutdown_asserted_d;
			seen_released_q <= seen_released_d;
			hold_count_q <= hold_count_d;
			grace_count_q <= grace_count_d;
		end
	end

	always_comb begin
		logic   ok, sw, req_eff, new_press;
		count_t limit, hold_inc;
		ok = item_s1.pwr_ok;
		sw = item_s1.switch_pressed;
		limit = clamp_count(cfg.force_off_ticks);
		new_press = sw && !prev_pressed_q;
		hold_inc = '0;
		req_eff = 1'b0;

		prev_pressed_d = sw;
		on_pending_d = on_pending_q;
		button_armed_d = button_armed_q;
		forced_done_d = forced_done_q;
		hold_count_d = hold_count_q;
		grace_count_d = grace_count_q;
		seen_released_d = seen_released_q;
		res_d = '0;

		if (item_s1.mode) begin
			on_pending_d = 1'b0;
			button_armed_d = sw && ok;
			forced_done_d = 1'b0;
			hold_count_d = '0;
			grace_count_d = clamp_count(cfg.grace_ticks);
			seen_released_d = 1'b0;
			shutdown_asserted_d = 1'b0;
		end else begin
			if (!ok) begin
				grace_count_d = clamp_count(cfg.grace_ticks);
			end else if (grace_count_q != '0) begin
				grace_count_d = grace_count_q - count_t'(1);
			end
			seen_released_d = ok && (seen_released_q || !item_s1.off_request);
			req_eff = item_s1.off_request && (grace_count_d == '0) && seen_released_d;

			if (req_eff) begin
				on_pending_d = 1'b0;
				button_armed_d = 1'b0;
				forced_done_d = 1'b0;
				hold_count_d = '0;
				res_d.psu_off = 1'b1;
			end else begin
				if (new_press) begin
					hold_count_d = '0;
					forced_done_d = 1'b0;
					button_armed_d = ok;
					if (!ok) begin
						on_pending_d = 1'b1;
						res_d.psu_on = 1'b1;
					end
				end
				if (ok) begin
					on_pending_d = 1'b0;
				end
				if (sw && button_armed_d && !forced_done_d) begin
					hold_inc = (hold_count_d < limit) ? hold_count_d + count_t'(1)
						: hold_count_d;
					hold_count_d = hold_inc;
					if (hold_inc >= limit) begin
						res_d.psu_off = 1'b1;
						button_armed_d = 1'b0;
						forced_done_d = 1'b1;
					end
				end
				if (!sw) begin
					hold_count_d = '0;
					forced_done_d = 1'b0;
				end
			end

			shutdown_asserted_d = button_armed_d;
			res_d.assert_shutdown = button_armed_d && !shutdown_asserted_q;
			res_d.deassert_shutdown = !button_armed_d && shutdown_asserted_q;
			res_d.shutdown_level = button_armed_d;
		end
	end

endmodule

@@ hw/rtl/soft_power_button_controller.sv @@
// Soft power button controller. Each request is one tick carrying a mode bit,
// PWR_OK, the IO controller's power-off request and the switch level, and
// yields exactly one result: PSU on/off pulses, shutdown line edges and the
// line level. One request is taken per clock unless result_ready stalls it; a
// result passes the input register and then the result register, and throughput
// is one per cycle under the same condition. The user must write the grace and
// force-off counts over the APB port (offsets 0x0 and 0x4) only while no request
// is in flight; the block itself does not enforce it. Reset loads 100 and 400.
`include "soft_power_button_controller_assert.svh"

module soft_power_button_controller import spbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_item_t             result
);

	cfg_t cfg;

	spbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spbc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`SPBC_ASSERT_EXCLUSIVE(a_edge_excl, result_valid && result.assert_shutdown, result.deassert_shutdown, "shutdown rise and fall together")
	`SPBC_ASSERT_EXCLUSIVE(a_psu_excl, result_valid && result.psu_on, result.psu_off, "psu on and off together")
	`SPBC_ASSERT_IMPLIES(a_rise_level, result_valid && result.assert_shutdown, result.shutdown_level, "rise without level")
	`SPBC_ASSERT_IMPLIES(a_on_level, result_valid && (result.psu_on || result.deassert_shutdown), !result.shutdown_level, "level high after power on or release")

endmodule
